/* rtl/core/srf_pkg.sv */
// Shared types and constants for the session replay filter.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package srf_pkg;

	localparam int HIST_DEPTH = 1024;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

	localparam logic [2:0] CMD_HELLO     = 3'd0;
	localparam logic [2:0] CMD_DISPATCH  = 3'd1;
	localparam logic [2:0] CMD_CANCEL    = 3'd2;
	localparam logic [2:0] CMD_QUIESCENT = 3'd3;
	// Every code from CMD_OTHER_LO up to CMD_OTHER_HI is an unknown frame kind.
	localparam logic [2:0] CMD_OTHER_LO  = 3'd4;
	localparam logic [2:0] CMD_OTHER_HI  = 3'd7;

	localparam logic [1:0] KIND_READY     = 2'd0;
	localparam logic [1:0] KIND_REFUSED   = 2'd1;
	localparam logic [1:0] KIND_CANCELLED = 2'd2;
	localparam logic [1:0] KIND_QUIESCENT = 2'd3;

	localparam logic [3:0] RC_OK             = 4'd0;
	localparam logic [3:0] RC_BAD_SESSION    = 4'd1;
	localparam logic [3:0] RC_BAD_NONCE      = 4'd2;
	localparam logic [3:0] RC_DUPLICATE      = 4'd3;
	localparam logic [3:0] RC_STALE          = 4'd4;
	localparam logic [3:0] RC_BAD_FRAME      = 4'd5;
	localparam logic [3:0] RC_BAD_TARGET     = 4'd6;
	localparam logic [3:0] RC_CANCELLED      = 4'd7;
	localparam logic [3:0] RC_CHANGED_TARGET = 4'd8;
	localparam logic [3:0] RC_UNSUPPORTED    = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_ROTATE,
		OP_INSERT
	} chain_op_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] session_hi;
		logic [63:0] session_lo;
		logic [63:0] request_hi;
		logic [63:0] request_lo;
		logic [63:0] nonce_hi;
		logic [63:0] nonce_lo;
		logic [63:0] seq_number;
		logic [63:0] window_handle;
		logic [31:0] process_id;
		logic [63:0] scene_id;
		logic        target_matches;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [3:0]  reason_code;
		logic [63:0] echo_sequence;
		logic [63:0] echo_session_hi;
		logic [63:0] echo_session_lo;
		logic [63:0] echo_request_hi;
		logic [63:0] echo_request_lo;
	} out_item_t;

endpackage

/* rtl/core/session_replay_filter.sv */
// Top level of the session replay filter: control state, history scan, reply.
// Depends on srf_pkg and srf_chain.
`timescale 1ns / 1ps

// Usage:
// Request frames enter on req (req_valid / req_stall); one reply per frame
// leaves on rsp (rsp_valid / rsp_stall). An item moves when valid is high and
// stall is low.
// The block handles one frame at a time. A hello goes straight to the decide
// step; any other frame first scans the request history, which is a row of
// cells that is rotated once fully past a single comparator. The next frame
// can be accepted in the cycle after the reply is loaded.
// req_stall is high from the accept until the reply is loaded.
// The reply sits in an output register; a new frame can be accepted while it
// waits. If the receiver stalls, a finished reply holds and the next frame
// waits in its final step until the register frees.
// Reset clears the binding, cancel flag, last sequence and history fill
// count; history contents need no clearing since only filled entries are
// compared. The block is ready right after reset.

module session_replay_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  srf_pkg::in_item_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output srf_pkg::out_item_t rsp
);
	import srf_pkg::*;

	state_t        state_q, state_d;
	in_item_t      frame_q;
	logic          hit_q, hit_d;
	logic [HIST_AW-1:0] idx_q, idx_d;
	logic          bound_q, cancelled_q;
	logic [63:0]   last_seq_q;
	logic [127:0]  session_q, nonce_q;
	logic [HIST_CW-1:0] count_q;
	logic          out_valid_q;
	out_item_t     out_q;

	chain_op_t     op;
	logic [127:0]  tail;
	logic [HIST_AW-1:0] age;
	logic          accept, emit, do_bind, do_commit, do_cancel;
	logic          any_target;
	logic [1:0]    kind;
	logic [3:0]    code;

	srf_chain u_chain (
		.clk (clk),
		.op  (op),
		.din ({frame_q.request_hi, frame_q.request_lo}),
		.tail(tail)
	);

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	// Entry under the comparator at scan step k sits k cells from the end.
	assign age       = HIST_AW'(HIST_DEPTH - 1) - idx_q;

	assign any_target = (frame_q.window_handle != '0) || (frame_q.process_id != '0)
		|| (frame_q.scene_id != '0);

	always_comb begin
		kind      = KIND_REFUSED;
		code      = RC_OK;
		do_bind   = 1'b0;
		do_commit = 1'b0;
		do_cancel = 1'b0;
		if (frame_q.command == CMD_HELLO) begin
			if (bound_q || frame_q.seq_number != '0 || any_target
				|| {frame_q.session_hi, frame_q.session_lo} == '0
				|| {frame_q.nonce_hi, frame_q.nonce_lo} == '0) begin
				code = RC_BAD_SESSION;
			end else begin
				kind    = KIND_READY;
				do_bind = 1'b1;
			end
		end else if (!bound_q || {frame_q.session_hi, frame_q.session_lo} != session_q) begin
			code = RC_BAD_SESSION;
		end else if ({frame_q.nonce_hi, frame_q.nonce_lo} != nonce_q) begin
			code = RC_BAD_NONCE;
		end else if (hit_q) begin
			code = RC_DUPLICATE;
		end else if (frame_q.seq_number == '0 || frame_q.seq_number <= last_seq_q) begin
			code = RC_STALE;
		end else if (frame_q.command != CMD_DISPATCH && frame_q.command != CMD_CANCEL
			&& frame_q.command != CMD_QUIESCENT) begin
			code = RC_BAD_FRAME;
		end else if (frame_q.command != CMD_DISPATCH && any_target) begin
			code = RC_BAD_TARGET;
		end else begin
			do_commit = 1'b1;
			if (frame_q.command == CMD_CANCEL) begin
				kind      = KIND_CANCELLED;
				do_cancel = 1'b1;
			end else if (frame_q.command == CMD_QUIESCENT) begin
				kind = KIND_QUIESCENT;
			end else if (cancelled_q) begin
				code = RC_CANCELLED;
			end else if (frame_q.process_id == '0 || frame_q.scene_id == '0
				|| frame_q.window_handle == '0) begin
				code = RC_BAD_TARGET;
			end else if (!frame_q.target_matches) begin
				code = RC_CHANGED_TARGET;
			end else begin
				code = RC_UNSUPPORTED;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		hit_d   = hit_q;
		op      = OP_HOLD;
		emit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					hit_d   = 1'b0;
					idx_d   = '0;
					state_d = (req.command == CMD_HELLO) ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				op = OP_ROTATE;
				if (tail == {frame_q.request_hi, frame_q.request_lo}
					&& HIST_CW'(age) < count_q) begin
					hit_d = 1'b1;
				end
				idx_d = idx_q + 1'b1;
				if (idx_q == HIST_AW'(HIST_DEPTH - 1)) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!out_valid_q || !rsp_stall) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (do_bind || do_commit) begin
						op = OP_INSERT;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_q       <= 1'b0;
			idx_q       <= '0;
			bound_q     <= 1'b0;
			cancelled_q <= 1'b0;
			last_seq_q  <= '0;
			session_q   <= '0;
			nonce_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_q   <= hit_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit && do_bind) begin
				bound_q   <= 1'b1;
				session_q <= {frame_q.session_hi, frame_q.session_lo};
				nonce_q   <= {frame_q.nonce_hi, frame_q.nonce_lo};
			end
			if (emit && do_commit) begin
				last_seq_q <= frame_q.seq_number;
			end
			if (emit && do_cancel) begin
				cancelled_q <= 1'b1;
			end
			if (emit && (do_bind || do_commit) && count_q != HIST_CW'(HIST_DEPTH)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= req;
		end
		if (emit) begin
			out_q.reply_kind      <= kind;
			out_q.reason_code     <= code;
			out_q.echo_sequence   <= frame_q.seq_number;
			out_q.echo_session_hi <= frame_q.session_hi;
			out_q.echo_session_lo <= frame_q.session_lo;
			out_q.echo_request_hi <= frame_q.request_hi;
			out_q.echo_request_lo <= frame_q.request_lo;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= HIST_CW'(HIST_DEPTH))
		else $error("history fill count above depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("frame accepted but block not busy");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || !rsp_stall))
		else $error("reply overwrote a pending reply");

	a_cancel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cancelled_q |-> bound_q)
		else $error("cancel recorded without a bound session");
endmodule

/* rtl/core/srf_cell.sv */
// One history cell: holds a 128-bit request ID and hands it to the next cell.
// Depends on srf_pkg.
`timescale 1ns / 1ps

module srf_cell (
	input  logic         clk,
	input  logic         en,
	input  logic [127:0] d,
	output logic [127:0] q
);
	import srf_pkg::*;

	logic [127:0] entry_q;

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;
endmodule

/* rtl/core/srf_chain.sv */
// Row of history cells, newest entry in the first cell.
// Rotating moves every entry one cell on and feeds the last back to the first.
// Depends on srf_pkg and srf_cell.
`timescale 1ns / 1ps

module srf_chain (
	input  logic              clk,
	input  srf_pkg::chain_op_t op,
	input  logic [127:0]      din,
	output logic [127:0]      tail
);
	import srf_pkg::*;

	logic [127:0] link [HIST_DEPTH];
	logic         en;
	logic [127:0] head_d;

	assign en     = (op != OP_HOLD);
	assign head_d = (op == OP_INSERT) ? din : link[HIST_DEPTH-1];

	for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			srf_cell u_cell (.clk(clk), .en(en), .d(head_d), .q(link[i]));
		end else begin : g_body
			srf_cell u_cell (.clk(clk), .en(en), .d(link[i-1]), .q(link[i]));
		end
	end

	assign tail = link[HIST_DEPTH-1];
endmodule
